### src/scrs_pkg.sv
// Shared types, constants and helpers for the serial command register slave.
package scrs_pkg;

  // Register file geometry
  localparam int NUM_REGS = 16;
  localparam int REG_AW   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int REG_DW   = 16;

  // Opcodes
  localparam logic [7:0] OP_WRITE = 8'h02;
  localparam logic [7:0] OP_READ  = 8'h03;

  // Register numbers with special behavior
  localparam int MODE_REG     = 0;
  localparam int STATUS_REG   = 1;
  localparam int HDR_REG_A    = 8;
  localparam int HDR_REG_B    = 9;
  localparam bit HDR_PRESENT  = (NUM_REGS > HDR_REG_B);
  localparam int RELOAD_BIT   = 2;

  localparam logic [REG_DW-1:0] MODE_RESET_VAL   = 16'h4000;
  localparam logic [REG_DW-1:0] STATUS_RESET_VAL = 16'h000C;

  // Position of the next byte within the frame
  typedef enum logic [2:0] {
    POS_IDLE,
    POS_ADDR,
    POS_DATA_HI,
    POS_DATA_LO,
    POS_DONE
  } frame_pos_t;

  typedef enum logic [1:0] {
    KIND_IGNORE,
    KIND_WRITE,
    KIND_READ
  } frame_kind_t;

  // Which register byte goes out on the reply
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_HIGH,
    SEL_LOW
  } reply_sel_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       write_done;
    logic       write_refused;
  } out_item_t;

  // Register file access requested by the frame controller for the current word
  typedef struct packed {
    logic              wr_en;
    logic              reload;
    logic [REG_AW-1:0] addr;
    logic [REG_DW-1:0] wr_data;
  } mem_req_t;

  // Per-word result flags that travel with the read
  typedef struct packed {
    reply_sel_t sel;
    logic       done;
    logic       refused;
  } step_info_t;

  function automatic logic [REG_DW-1:0] reg_reset_value(logic [REG_AW-1:0] idx);
    logic [REG_DW-1:0] val;
    val = '0;
    if (int'(idx) == MODE_REG) begin
      val = MODE_RESET_VAL;
    end else if (int'(idx) == STATUS_REG) begin
      val = STATUS_RESET_VAL;
    end
    return val;
  endfunction

  function automatic logic is_read_only(logic [REG_AW-1:0] idx);
    return HDR_PRESENT && (int'(idx) == HDR_REG_A || int'(idx) == HDR_REG_B);
  endfunction

endpackage

### src/scrs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module scrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/scrs_frame_ctrl.sv
// Frame decoder: tracks byte position, opcode and target, issues register file accesses.
module scrs_frame_ctrl
  import scrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  in_item_t   item,
  output mem_req_t   mem_req,
  output step_info_t step_info
);

  frame_pos_t        pos_r, pos_nxt;
  frame_kind_t       kind_r, kind_nxt;
  logic [REG_AW-1:0] tgt_r, tgt_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic              addr_ok;
  logic [REG_DW-1:0] wr_word;

  assign addr_ok = item.byte_in < 8'(NUM_REGS);
  assign wr_word = {hi_r, item.byte_in};

  // Next state
  always_comb begin
    pos_nxt = pos_r;
    if (item.frame_start) begin
      pos_nxt = POS_ADDR;
    end else begin
      case (pos_r)
        POS_IDLE:    pos_nxt = POS_IDLE;
        POS_ADDR:    pos_nxt = POS_DATA_HI;
        POS_DATA_HI: pos_nxt = POS_DATA_LO;
        POS_DATA_LO: pos_nxt = POS_DONE;
        POS_DONE:    pos_nxt = POS_DONE;
        default:     pos_nxt = POS_IDLE;
      endcase
    end
  end

  // Frame context updates
  always_comb begin
    kind_nxt = kind_r;
    tgt_nxt  = tgt_r;
    hi_nxt   = hi_r;
    if (item.frame_start) begin
      case (item.byte_in)
        OP_WRITE: kind_nxt = KIND_WRITE;
        OP_READ:  kind_nxt = KIND_READ;
        default:  kind_nxt = KIND_IGNORE;
      endcase
    end else if (pos_r == POS_ADDR) begin
      if (addr_ok) begin
        tgt_nxt = item.byte_in[REG_AW-1:0];
      end else begin
        kind_nxt = KIND_IGNORE;
      end
    end else if (pos_r == POS_DATA_HI && kind_r == KIND_WRITE) begin
      hi_nxt = item.byte_in;
    end
  end

  // Outputs: reply select, write done and refused flags, write and reload requests
  always_comb begin
    mem_req.wr_en     = 1'b0;
    mem_req.reload    = 1'b0;
    mem_req.addr      = tgt_r;
    mem_req.wr_data   = wr_word;
    step_info.sel     = SEL_NONE;
    step_info.done    = 1'b0;
    step_info.refused = 1'b0;
    if (!item.frame_start) begin
      case (pos_r)
        POS_DATA_HI: begin
          if (kind_r == KIND_READ) begin
            step_info.sel = SEL_HIGH;
          end
        end
        POS_DATA_LO: begin
          if (kind_r == KIND_READ) begin
            step_info.sel = SEL_LOW;
          end else if (kind_r == KIND_WRITE) begin
            if (is_read_only(tgt_r)) begin
              step_info.refused = 1'b1;
            end else begin
              step_info.done = 1'b1;
              if (int'(tgt_r) == MODE_REG && wr_word[RELOAD_BIT]) begin
                mem_req.reload = accept;
              end else begin
                mem_req.wr_en = accept;
              end
            end
          end
        end
        default: begin
          step_info.sel = SEL_NONE;
        end
      endcase
    end
  end

  // Frame registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_IDLE;
      kind_r <= KIND_IGNORE;
      tgt_r  <= '0;
      hi_r   <= '0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      kind_r <= kind_nxt;
      tgt_r  <= tgt_nxt;
      hi_r   <= hi_nxt;
    end
  end

endmodule

### src/spi_command_register_slave.sv
// Top level of the serial command register slave: register file, read stage and output word.
// Takes one received byte per word and returns one reply word per byte. A word can be
// accepted every clock cycle unless the input stalls; its reply passes through the registered
// read of the register file and then the output register. The register file sits in a 16x16
// RAM; per-entry valid bits, cleared by reset and by a mode reload, make an entry that was not
// written since then read as its reset value, so no clearing pass is needed. Input stalls only
// when both the read stage and the output word are full and the output is stalled.
module spi_command_register_slave
  import scrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  typedef struct packed {
    step_info_t        info;
    logic              entry_valid;
    logic [REG_AW-1:0] addr;
  } rd_stage_t;

  logic              in_accept;
  mem_req_t          mem_req;
  step_info_t        step_info;
  logic [REG_DW-1:0] rd_data;
  logic [NUM_REGS-1:0] entry_valid_r, entry_valid_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  rd_stage_t         s1_r;
  logic              s1_move;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  logic [REG_DW-1:0] reg_word;

  // Handshake
  assign s1_move   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  scrs_frame_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .item      (in_item),
    .mem_req   (mem_req),
    .step_info (step_info)
  );

  scrs_ram #(
    .WIDTH (REG_DW),
    .DEPTH (NUM_REGS)
  ) u_regfile (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (in_accept),
    .rd_addr (mem_req.addr),
    .rd_data (rd_data)
  );

  // Entry valid bits: set on write, all cleared by reload
  always_comb begin
    entry_valid_nxt = entry_valid_r;
    if (mem_req.reload) begin
      entry_valid_nxt = '0;
    end else if (mem_req.wr_en) begin
      entry_valid_nxt[mem_req.addr] = 1'b1;
    end
  end

  // Output word from the read stage
  always_comb begin
    reg_word = s1_r.entry_valid ? rd_data : reg_reset_value(s1_r.addr);
    out_nxt.write_done    = s1_r.info.done;
    out_nxt.write_refused = s1_r.info.refused;
    case (s1_r.info.sel)
      SEL_HIGH: out_nxt.byte_out = reg_word[REG_DW-1:8];
      SEL_LOW:  out_nxt.byte_out = reg_word[7:0];
      default:  out_nxt.byte_out = '0;
    endcase
  end

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !s1_move);
  assign out_valid_nxt = s1_move || (out_valid_r && out_stall);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      entry_valid_r <= entry_valid_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r.info        <= step_info;
      s1_r.entry_valid <= entry_valid_r[mem_req.addr];
      s1_r.addr        <= mem_req.addr;
    end
    if (s1_move) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef ASSERT_OFF
  // A word never reports both a completed and a refused write
  a_done_xor_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.write_done && out_item.write_refused))
    else $error("write_done and write_refused both set");

  // Input stalls only when the pipeline is full and the output is held
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && s1_valid_r))
    else $error("input stalled with room in the pipeline");

  // A mode reload leaves every entry at its reset value
  a_reload_clears: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.reload |=> (entry_valid_r == '0))
    else $error("reload did not clear entry valid bits");

  // A write occurs only for an accepted word and never together with a reload
  a_wr_reload_excl: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (!mem_req.reload && in_accept))
    else $error("register write without accepted word or with reload");
`endif

endmodule
